// ----- design/trcvc_pkg.sv -----
// ----------------------------------------------------------------------------
// trcvc_pkg
// Shared types, character codes and the per-column classification function
// of the three-row column vote classifier.
// ----------------------------------------------------------------------------
package trcvc_pkg;

    // ASCII codes
    localparam logic [7:0] CHAR_GAP     = 8'h2D;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_C       = 8'h43;
    localparam logic [7:0] CHAR_G       = 8'h47;
    localparam logic [7:0] CHAR_T       = 8'h54;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Difference classes
    localparam logic [2:0] DIFF_IGNORE  = 3'd0;
    localparam logic [2:0] DIFF_NO_VOTE = 3'd1;
    localparam logic [2:0] DIFF_MATCH_A = 3'd2;
    localparam logic [2:0] DIFF_MATCH_B = 3'd3;
    localparam logic [2:0] DIFF_ABSTAIN = 3'd4;

    // One result beat waiting in the output queue
    typedef struct packed {
        logic [2:0] diff_class;
        logic       end_of_alignment;
    } t_result;

    // Fold lower-case ASCII letters to upper case
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic is_base(input logic [7:0] c);
        return (c == CHAR_A) || (c == CHAR_C) || (c == CHAR_G) || (c == CHAR_T);
    endfunction

    function automatic logic column_has_gap(input logic [7:0] q, input logic [7:0] a,
                                            input logic [7:0] b);
        return (q == CHAR_GAP) || (a == CHAR_GAP) || (b == CHAR_GAP);
    endfunction

    // Class of a column on its own, neighbor gaps not yet applied
    function automatic logic [2:0] classify(input logic [7:0] q_raw, input logic [7:0] a_raw,
                                            input logic [7:0] b_raw);
        logic [7:0] q;
        logic [7:0] a;
        logic [7:0] b;
        logic [2:0] r;
        q = fold_case(q_raw);
        a = fold_case(a_raw);
        b = fold_case(b_raw);
        if (!is_base(q) || !is_base(a) || !is_base(b)) begin
            r = DIFF_IGNORE;
        end else if (a == b) begin
            r = (q == a) ? DIFF_IGNORE : DIFF_NO_VOTE;
        end else if (q == a) begin
            r = DIFF_MATCH_A;
        end else if (q == b) begin
            r = DIFF_MATCH_B;
        end else begin
            r = DIFF_ABSTAIN;
        end
        return r;
    endfunction

endpackage

// ----- design/three_row_column_vote_classifier.sv -----
// A column's result beat is written into the output queue when the next column is accepted;
// accepting a last column writes the held column's beat and then its own end-of-alignment beat.
// Throughput: one column per cycle while two queue entries are free; the four-entry output queue
// drains one beat per ready cycle; a last column's extra beat fits, as the next column pushes none.
// Reset (synchronous, active low) empties the queue and drops any held column.
// ----------------------------------------------------------------------------
// three_row_column_vote_classifier
// Classifies each column of a query / parent A / parent B alignment by which
// parent the query agrees with, ignoring columns next to gaps.
// ----------------------------------------------------------------------------
module three_row_column_vote_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] query_base, [15:8] parent_a_base,
                                        // [23:16] parent_b_base
    input  logic        s_axis_tlast,   // final_column
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] diff_class, [7:3] zero
    output logic        m_axis_tlast    // end_of_alignment
);
    import trcvc_pkg::*;

    localparam int QDEPTH = 4;

    // Held column: its own class, its gap flag, and a gap in the column before it
    logic       r_pend_valid;
    logic [2:0] r_pend_class;
    logic       r_pend_gap;
    logic       r_gap_prev;

    // Output queue
    t_result    r_queue [QDEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;

    logic [7:0] cur_q;
    logic [7:0] cur_a;
    logic [7:0] cur_b;
    logic       cur_gap;
    logic [2:0] cur_class;
    logic       before_cur;
    logic       s_beat;
    logic       m_beat;
    t_result    res_held;
    t_result    res_last;
    logic [1:0] last_ptr;
    logic [2:0] n_push;
    logic [2:0] n_count;

    assign cur_q = s_axis_tdata[7:0];
    assign cur_a = s_axis_tdata[15:8];
    assign cur_b = s_axis_tdata[23:16];

    // Accept a column only while room for two result beats remains
    assign s_axis_tready = (r_count <= 3'(QDEPTH - 2));
    assign s_beat        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_count != 3'd0);
    assign m_beat        = m_axis_tvalid && m_axis_tready;

    // Classify the held column now that its successor is known; classify a last column at once
    always_comb begin
        cur_gap    = column_has_gap(cur_q, cur_a, cur_b);
        cur_class  = classify(cur_q, cur_a, cur_b);
        before_cur = r_pend_valid && r_pend_gap;

        res_held.diff_class       = (r_gap_prev || r_pend_gap || cur_gap) ? DIFF_IGNORE
                                                                           : r_pend_class;
        res_held.end_of_alignment = 1'b0;
        res_last.diff_class       = (before_cur || cur_gap) ? DIFF_IGNORE : cur_class;
        res_last.end_of_alignment = 1'b1;

        last_ptr = r_wr_ptr + {1'b0, r_pend_valid};
        n_push   = s_beat ? (3'({2'b0, r_pend_valid}) + 3'({2'b0, s_axis_tlast})) : 3'd0;
        n_count  = r_count + n_push - (m_beat ? 3'd1 : 3'd0);
    end

    // Hold state and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_gap_prev   <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            r_count  <= n_count;
            r_wr_ptr <= r_wr_ptr + n_push[1:0];
            if (m_beat) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            if (s_beat) begin
                if (s_axis_tlast) begin
                    r_pend_valid <= 1'b0;
                    r_gap_prev   <= 1'b0;
                end else begin
                    r_pend_valid <= 1'b1;
                    r_gap_prev   <= before_cur;
                end
            end
        end
    end

    // Capture held column payload and push result beats
    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_pend_class <= cur_class;
            r_pend_gap   <= cur_gap;
            if (r_pend_valid) begin
                r_queue[r_wr_ptr] <= res_held;
            end
            if (s_axis_tlast) begin
                r_queue[last_ptr] <= res_last;
            end
        end
    end

    assign m_axis_tdata = {5'b0, r_queue[r_rd_ptr].diff_class};
    assign m_axis_tlast = r_queue[r_rd_ptr].end_of_alignment;

endmodule
